[rtl/dual_button_debounce_long_press_core_assert.svh]
// Assertion macros shared by the debounce core.
`ifndef DUAL_BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH
`define DUAL_BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH

// Check cons on the same edge as ante.
`define DBDLP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dbdlp assertion failed");

// Check cons on the edge after ante.
`define DBDLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dbdlp assertion failed");

`endif

[rtl/dbdlp_pkg.sv]
// Shared types and constants of the dual button debounce core.
package dbdlp_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int NOW_MS_BITS       = 32;
    localparam int CFG_DATA_BITS     = 16;
    localparam int CFG_INDEX_BITS    = 4;

    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic                     IDLE_LEVEL_RESET = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE    = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS  = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLEAR_IDLE  = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOGGLE_IDLE = 4'd3;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] debounce_ms;
        logic [CFG_DATA_BITS-1:0] long_press_ms;
        logic                     clear_idle_level;
        logic                     toggle_idle_level;
    } t_cfg;

    typedef struct packed {
        logic short_press;
        logic long_press;
        logic stable_level;
    } t_btn_evt;

endpackage

[rtl/dbdlp_cfg.sv]
// Configuration register file of the dual button debounce core.
module dbdlp_cfg
    import dbdlp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:    n_cfg.debounce_ms       = i_cfg_data;
                CFG_LONG_PRESS:  n_cfg.long_press_ms     = i_cfg_data;
                CFG_CLEAR_IDLE:  n_cfg.clear_idle_level  = i_cfg_data[0];
                CFG_TOGGLE_IDLE: n_cfg.toggle_idle_level = i_cfg_data[0];
                default:         n_cfg                   = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms       <= DEBOUNCE_RESET;
            r_cfg.long_press_ms     <= LONG_PRESS_RESET;
            r_cfg.clear_idle_level  <= IDLE_LEVEL_RESET;
            r_cfg.toggle_idle_level <= IDLE_LEVEL_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/dbdlp_button.sv]
// Per-button debounce, press tracking and short/long press detection.
module dbdlp_button
    import dbdlp_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic [TIME_BITS-1:0]     i_now,
    input  logic                     i_level,
    input  logic                     i_idle_level,
    input  logic [CFG_DATA_BITS-1:0] i_debounce_ms,
    input  logic [CFG_DATA_BITS-1:0] i_long_press_ms,
    output t_btn_evt                 o_evt
);

    logic                 r_raw;
    logic                 r_stable;
    logic                 r_long_done;
    logic                 r_active;
    logic [TIME_BITS-1:0] r_change_time;
    logic [TIME_BITS-1:0] r_press_time;

    logic                 n_raw;
    logic                 n_stable;
    logic                 n_long_done;
    logic                 n_active;
    logic [TIME_BITS-1:0] n_change_time;
    logic [TIME_BITS-1:0] n_press_time;

    logic                 w_changed;
    logic                 w_settled;
    logic                 w_long_due;
    logic [TIME_BITS-1:0] w_since_change;
    logic [TIME_BITS-1:0] w_since_press;

    assign w_changed      = (i_level != r_raw);
    assign w_since_change = i_now - r_change_time;
    assign w_since_press  = i_now - r_press_time;
    assign w_settled      = !w_changed && (w_since_change > TIME_BITS'(i_debounce_ms));
    assign w_long_due     = (w_since_press >= TIME_BITS'(i_long_press_ms));

    always_comb begin
        n_raw         = i_level;
        n_stable      = r_stable;
        n_long_done   = r_long_done;
        n_active      = r_active;
        n_change_time = w_changed ? i_now : r_change_time;
        n_press_time  = r_press_time;
        o_evt         = '0;
        if (w_settled) begin
            if (r_raw != r_stable) begin
                n_stable = r_raw;
                if (r_raw != i_idle_level) begin
                    n_press_time = i_now;
                    n_long_done  = 1'b0;
                    n_active     = 1'b1;
                end else begin
                    o_evt.short_press = !r_long_done;
                    n_press_time      = '0;
                    n_long_done       = 1'b0;
                    n_active          = 1'b0;
                end
            end else if (r_stable != i_idle_level && !r_long_done && r_active
                         && w_long_due) begin
                o_evt.long_press = 1'b1;
                n_long_done      = 1'b1;
            end
        end
        o_evt.stable_level = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw         <= IDLE_LEVEL_RESET;
            r_stable      <= IDLE_LEVEL_RESET;
            r_long_done   <= 1'b0;
            r_active      <= 1'b0;
            r_change_time <= '0;
            r_press_time  <= '0;
        end else if (i_adv) begin
            r_raw         <= n_raw;
            r_stable      <= n_stable;
            r_long_done   <= n_long_done;
            r_active      <= n_active;
            r_change_time <= n_change_time;
            r_press_time  <= n_press_time;
        end
    end

endmodule

[rtl/dual_button_debounce_long_press_core.sv]
// Top level of the dual button debounce core with short and long press events.
//
// Input channel (i_in_valid / o_in_ready): one poll request with a millisecond
// timestamp and the raw levels of the clear and toggle buttons.
// Output channel (o_out_valid / i_out_ready): one result per poll with the
// short/long press pulses and the debounced level of each button.
// Configuration channel (i_cfg_valid / o_cfg_ready): register index and data;
// debounce time, long press time and the idle level of each button. Write
// only while no poll is in flight.
// A poll accepted into the input register passes to the result register once
// that is empty or being read, and is offered to the receiver from there.
// Throughput: one poll per cycle while the receiver does not stall, set by
// the single-pass per-button compare-and-update between the two registers.
// A stalled output holds its result; the input register still takes a new
// poll while the result register is occupied, and o_in_ready drops only when
// both are full and the receiver is stalling.
// Reset: both buttons start released at level 1 with zeroed timers, debounce
// time 50 ms, long press time 1000 ms, idle levels 1; no request is pending.
`include "dual_button_debounce_long_press_core_assert.svh"

module dual_button_debounce_long_press_core
    import dbdlp_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [NOW_MS_BITS-1:0]    i_now_ms,
    input  logic                      i_clear_level,
    input  logic                      i_toggle_level,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_clear_short_press,
    output logic                      o_clear_long_press,
    output logic                      o_toggle_short_press,
    output logic                      o_toggle_long_press,
    output logic                      o_clear_stable_level,
    output logic                      o_toggle_stable_level,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_cfg                   w_cfg;
    t_btn_evt               w_clear_evt;
    t_btn_evt               w_toggle_evt;
    logic [TIME_BITS-1:0]   w_now;
    logic                   w_adv;

    logic                   r_in_valid;
    logic [NOW_MS_BITS-1:0] r_now_ms;
    logic                   r_clear_level;
    logic                   r_toggle_level;
    logic                   r_out_valid;
    t_btn_evt               r_clear_evt;
    t_btn_evt               r_toggle_evt;

    dbdlp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign w_now      = TIME_BITS'(r_now_ms);
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    dbdlp_button #(
        .TIME_BITS (TIME_BITS)
    ) u_clear (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_now           (w_now),
        .i_level         (r_clear_level),
        .i_idle_level    (w_cfg.clear_idle_level),
        .i_debounce_ms   (w_cfg.debounce_ms),
        .i_long_press_ms (w_cfg.long_press_ms),
        .o_evt           (w_clear_evt)
    );

    dbdlp_button #(
        .TIME_BITS (TIME_BITS)
    ) u_toggle (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_now           (w_now),
        .i_level         (r_toggle_level),
        .i_idle_level    (w_cfg.toggle_idle_level),
        .i_debounce_ms   (w_cfg.debounce_ms),
        .i_long_press_ms (w_cfg.long_press_ms),
        .o_evt           (w_toggle_evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_now_ms       <= i_now_ms;
            r_clear_level  <= i_clear_level;
            r_toggle_level <= i_toggle_level;
        end
        if (w_adv) begin
            r_clear_evt  <= w_clear_evt;
            r_toggle_evt <= w_toggle_evt;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_clear_short_press   = r_clear_evt.short_press;
    assign o_clear_long_press    = r_clear_evt.long_press;
    assign o_toggle_short_press  = r_toggle_evt.short_press;
    assign o_toggle_long_press   = r_toggle_evt.long_press;
    assign o_clear_stable_level  = r_clear_evt.stable_level;
    assign o_toggle_stable_level = r_toggle_evt.stable_level;

    `DBDLP_ASSERT_SAME(a_clear_one_event, r_out_valid, !(r_clear_evt.short_press && r_clear_evt.long_press))
    `DBDLP_ASSERT_SAME(a_toggle_one_event, r_out_valid, !(r_toggle_evt.short_press && r_toggle_evt.long_press))
    `DBDLP_ASSERT_NEXT(a_request_held, i_in_valid && o_in_ready, r_in_valid)
    `DBDLP_ASSERT_NEXT(a_result_loaded, w_adv, r_out_valid)

endmodule
